// ----- rtl/dpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dpp_pkg;

   typedef enum logic [3:0] {
      PH_ETH      = 4'd0,
      PH_IP       = 4'd1,
      PH_UDP      = 4'd2,
      PH_BOOTP    = 4'd3,
      PH_OPT_CODE = 4'd4,
      PH_OPT_LEN  = 4'd5,
      PH_OPT_DATA = 4'd6,
      PH_DONE     = 4'd7,
      PH_REJECT   = 4'd8
   } phase_type;

   localparam logic [4:0] K_XID      = 5'd0;
   localparam logic [4:0] K_BCAST    = 5'd1;
   localparam logic [4:0] K_CIADDR   = 5'd2;
   localparam logic [4:0] K_IPSRC    = 5'd6;
   localparam logic [4:0] K_IPDST    = 5'd7;
   localparam logic [4:0] K_MAC      = 5'd8;
   localparam logic [4:0] K_MASK     = 5'd9;
   localparam logic [4:0] K_ROUTER   = 5'd10;
   localparam logic [4:0] K_DNS      = 5'd11;
   localparam logic [4:0] K_BCADDR   = 5'd12;
   localparam logic [4:0] K_REQIP    = 5'd13;
   localparam logic [4:0] K_LEASE    = 5'd14;
   localparam logic [4:0] K_SERVERID = 5'd15;
   localparam logic [4:0] K_MSGTYPE  = 5'd16;
   localparam logic [4:0] K_OPTBYTE  = 5'd17;
   localparam logic [4:0] K_STATUS   = 5'd18;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NOT_IPV4  = 4'd1;
   localparam logic [3:0] ST_NOT_UDP   = 4'd2;
   localparam logic [3:0] ST_BAD_PORT  = 4'd3;
   localparam logic [3:0] ST_BAD_HLEN  = 4'd4;
   localparam logic [3:0] ST_BAD_COOK  = 4'd5;
   localparam logic [3:0] ST_BAD_OLEN  = 4'd6;
   localparam logic [3:0] ST_NO_TYPE   = 4'd7;
   localparam logic [3:0] ST_UNK_TYPE  = 4'd8;
   localparam logic [3:0] ST_TRUNC     = 4'd9;

   localparam logic [1:0] MODE_ETH = 2'd0;
   localparam logic [1:0] MODE_IP  = 2'd1;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic [7:0]  code;
      logic [7:0]  index;
      logic [3:0]  status;
      logic        eop;
   } rec_type;

   // One classified input word: up to two records.
   typedef struct packed {
      logic    v0;
      rec_type r0;
      logic    v1;
      rec_type r1;
   } entry_type;

   localparam int QDEPTH = 4;
   localparam int QAW = 2;

endpackage
`default_nettype wire

// ----- rtl/dhcp_packet_parser.sv -----
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_data_byte, req_last_byte
// rsp     | out       | rsp_valid, rsp_ready, rsp_record_kind .. rsp_end_of_packet
// csr     | in        | csr_we, csr_wdata (encap_mode)
// One byte word is accepted per cycle while the four-entry queue has room.
// The front classifies a byte in the cycle it is accepted; records leave one
// per cycle from the queue head while rsp_ready is high, the status record last.
// Reset is synchronous and active high. A stalled rsp side fills the queue and
// then drops req_ready.
`timescale 1ns / 1ps
`default_nettype none
module dhcp_packet_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [4:0]       rsp_record_kind,
   output logic [31:0]      rsp_record_value,
   output logic [7:0]       rsp_option_code,
   output logic [7:0]       rsp_byte_index,
   output logic [3:0]       rsp_packet_status,
   output logic             rsp_end_of_packet
);

   dpp_pkg::entry_type ent, qd;
   dpp_pkg::rec_type   rec;
   logic full, empty, pop, acc;

   assign req_ready = !full;
   assign acc = req_valid && !full;

   dpp_front u_front (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(acc), .in_byte(req_data_byte), .in_last(req_last_byte), .ent
   );

   dpp_queue u_queue (
      .clock, .reset, .wr_en(acc && (ent.v0 || ent.v1)), .wr_data(ent),
      .full, .empty, .rd_en(pop), .rd_data(qd)
   );

   dpp_back u_back (
      .clock, .reset, .q_empty(empty), .q_data(qd), .q_pop(pop),
      .out_valid(rsp_valid), .out_rec(rec), .out_ready(rsp_ready)
   );

   assign rsp_record_kind   = rec.kind;
   assign rsp_record_value  = rec.value;
   assign rsp_option_code   = rec.code;
   assign rsp_byte_index    = rec.index;
   assign rsp_packet_status = rec.status;
   assign rsp_end_of_packet = rec.eop;

endmodule
`default_nettype wire

// ----- rtl/dpp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dpp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_wdata,
   input  wire logic               in_valid,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   output dpp_pkg::entry_type      ent
);

   logic [1:0]          mode_ff;
   dpp_pkg::phase_type  phase_ff, phase_in;
   logic [8:0]          off_ff, off_in;
   logic [7:0]          opt_ff, opt_in;
   logic [7:0]          olen_ff, olen_in;
   logic [7:0]          orem_ff, orem_in;
   logic [31:0]         acc_ff, acc_in;
   logic [7:0]          hlen_ff, hlen_in;
   logic [7:0]          mtype_ff, mtype_in;
   logic [3:0]          err_ff, err_in;
   logic                open_ff;
   logic [7:0]          idx, orem_dec;
   logic [31:0]         shifted;
   logic [4:0]          fkind;
   logic                len_ok, byte_opt;
   logic [3:0]          st;
   dpp_pkg::rec_type    rec;

   function automatic dpp_pkg::phase_type start_of(input logic [1:0] m);
      if (m == dpp_pkg::MODE_ETH) return dpp_pkg::PH_ETH;
      else if (m == dpp_pkg::MODE_IP) return dpp_pkg::PH_IP;
      else return dpp_pkg::PH_BOOTP;
   endfunction

   assign shifted  = {acc_ff[23:0], in_byte};
   assign idx      = olen_ff - orem_ff;
   assign orem_dec = orem_ff - 8'd1;

   always_comb begin
      case (opt_ff)
         8'd1:    fkind = dpp_pkg::K_MASK;
         8'd3:    fkind = dpp_pkg::K_ROUTER;
         8'd28:   fkind = dpp_pkg::K_BCADDR;
         8'd50:   fkind = dpp_pkg::K_REQIP;
         8'd51:   fkind = dpp_pkg::K_LEASE;
         8'd54:   fkind = dpp_pkg::K_SERVERID;
         default: fkind = dpp_pkg::K_XID;
      endcase
      case (opt_ff)
         8'd1, 8'd3, 8'd28, 8'd50, 8'd51, 8'd54: len_ok = (in_byte == 8'd4);
         8'd53:   len_ok = (in_byte == 8'd1);
         8'd6:    len_ok = (in_byte[1:0] == 2'd0);
         default: len_ok = 1'b1;
      endcase
      byte_opt = (opt_ff == 8'd12) || (opt_ff == 8'd15) || (opt_ff == 8'd55) ||
                 (opt_ff == 8'd56) || (opt_ff == 8'd60) || (opt_ff == 8'd61);
   end

   always_comb begin
      phase_in = phase_ff; off_in = off_ff; opt_in = opt_ff; olen_in = olen_ff;
      orem_in = orem_ff; acc_in = acc_ff; hlen_in = hlen_ff; mtype_in = mtype_ff;
      err_in = err_ff;
      rec = '0;
      ent = '0;
      st = dpp_pkg::ST_OK;
      if (in_valid) begin
         unique case (phase_ff)
            dpp_pkg::PH_ETH: begin
               acc_in = shifted;
               off_in = off_ff + 9'd1;
               if (off_ff == 9'd13) begin
                  off_in = '0;
                  if (shifted[15:0] != 16'h0800) begin
                     err_in = dpp_pkg::ST_NOT_IPV4; phase_in = dpp_pkg::PH_REJECT;
                  end else phase_in = dpp_pkg::PH_IP;
               end
            end
            dpp_pkg::PH_IP: begin
               acc_in = shifted;
               if (off_ff == 9'd9) opt_in = in_byte;
               off_in = off_ff + 9'd1;
               if (off_ff == 9'd15) begin
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_IPSRC; rec.value = shifted;
               end
               if (off_ff == 9'd19) begin
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_IPDST; rec.value = shifted;
                  off_in = '0;
                  if (opt_ff != 8'h11) begin
                     err_in = dpp_pkg::ST_NOT_UDP; phase_in = dpp_pkg::PH_REJECT;
                  end else phase_in = dpp_pkg::PH_UDP;
                  opt_in = '0;
               end
            end
            dpp_pkg::PH_UDP: begin
               if (off_ff < 9'd2) acc_in = shifted;
               off_in = off_ff + 9'd1;
               if (off_ff == 9'd7) begin
                  off_in = '0;
                  if (acc_ff[15:0] != 16'd67 && acc_ff[15:0] != 16'd68) begin
                     err_in = dpp_pkg::ST_BAD_PORT; phase_in = dpp_pkg::PH_REJECT;
                  end else phase_in = dpp_pkg::PH_BOOTP;
               end
            end
            dpp_pkg::PH_BOOTP: begin
               acc_in = shifted;
               off_in = off_ff + 9'd1;
               if (off_ff == 9'd2) begin
                  hlen_in = in_byte;
                  if (in_byte > 8'd16) begin
                     err_in = dpp_pkg::ST_BAD_HLEN; phase_in = dpp_pkg::PH_REJECT;
                  end
               end else if (off_ff == 9'd7) begin
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_XID; rec.value = shifted;
               end else if (off_ff == 9'd11) begin
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_BCAST;
                  rec.value = {31'd0, shifted[15]};
               end else if (off_ff == 9'd15 || off_ff == 9'd19 || off_ff == 9'd23 ||
                            off_ff == 9'd27) begin
                  ent.v0 = 1'b1; rec.value = shifted;
                  rec.kind = dpp_pkg::K_CIADDR + {1'b0, off_ff[4:2]} - 5'd3;
               end else if (off_ff >= 9'd28 && off_ff < 9'd28 + {1'b0, hlen_ff}) begin
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_MAC; rec.value = {24'd0, in_byte};
                  rec.index = 8'(off_ff - 9'd28);
               end else if (off_ff == 9'd239) begin
                  off_in = '0;
                  if (shifted != 32'h63825363) begin
                     err_in = dpp_pkg::ST_BAD_COOK; phase_in = dpp_pkg::PH_REJECT;
                  end else phase_in = dpp_pkg::PH_OPT_CODE;
               end
            end
            dpp_pkg::PH_OPT_CODE: begin
               if (in_byte == 8'hFF) phase_in = dpp_pkg::PH_DONE;
               else if (in_byte != 8'd0) begin
                  opt_in = in_byte; phase_in = dpp_pkg::PH_OPT_LEN;
               end
            end
            dpp_pkg::PH_OPT_LEN: begin
               olen_in = in_byte; orem_in = in_byte; acc_in = '0;
               if (!len_ok) begin
                  err_in = dpp_pkg::ST_BAD_OLEN; phase_in = dpp_pkg::PH_REJECT;
               end else if (in_byte == 8'd0) phase_in = dpp_pkg::PH_OPT_CODE;
               else phase_in = dpp_pkg::PH_OPT_DATA;
            end
            dpp_pkg::PH_OPT_DATA: begin
               acc_in = shifted;
               orem_in = orem_dec;
               if (opt_ff == 8'd53) begin
                  mtype_in = in_byte;
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_MSGTYPE; rec.value = {24'd0, in_byte};
               end else if (opt_ff == 8'd6) begin
                  if (idx[1:0] == 2'd3) begin
                     ent.v0 = 1'b1; rec.kind = dpp_pkg::K_DNS; rec.value = shifted;
                  end
               end else if (fkind != dpp_pkg::K_XID) begin
                  if (orem_dec == 8'd0) begin
                     ent.v0 = 1'b1; rec.kind = fkind; rec.value = shifted;
                  end
               end else if (byte_opt) begin
                  ent.v0 = 1'b1; rec.kind = dpp_pkg::K_OPTBYTE;
                  rec.value = {24'd0, in_byte}; rec.code = opt_ff; rec.index = idx;
               end
               if (orem_dec == 8'd0) phase_in = dpp_pkg::PH_OPT_CODE;
            end
            default: ;
         endcase
         ent.r0 = rec;
         if (in_last) begin
            if (phase_in == dpp_pkg::PH_REJECT) st = err_in;
            else if (phase_in == dpp_pkg::PH_OPT_CODE || phase_in == dpp_pkg::PH_DONE) begin
               if (mtype_in == 8'hFF) st = dpp_pkg::ST_NO_TYPE;
               else if ((mtype_in >= 8'd1 && mtype_in <= 8'd6) || mtype_in == 8'd8)
                  st = dpp_pkg::ST_OK;
               else st = dpp_pkg::ST_UNK_TYPE;
            end else st = dpp_pkg::ST_TRUNC;
            ent.v1 = 1'b1;
            ent.r1.kind = dpp_pkg::K_STATUS;
            ent.r1.value = {28'd0, st};
            ent.r1.code = '0;
            ent.r1.index = '0;
            ent.r1.status = st;
            ent.r1.eop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0; phase_ff <= dpp_pkg::PH_ETH; off_ff <= '0; opt_ff <= '0;
         olen_ff <= '0; orem_ff <= '0; acc_ff <= '0; hlen_ff <= '0;
         mtype_ff <= 8'hFF; err_ff <= '0; open_ff <= 1'b0;
      end else begin
         if (csr_we) mode_ff <= csr_wdata;
         if (in_valid && in_last) begin
            phase_ff <= start_of(csr_we ? csr_wdata : mode_ff);
            off_ff <= '0; opt_ff <= '0; olen_ff <= '0; orem_ff <= '0; acc_ff <= '0;
            hlen_ff <= '0; mtype_ff <= 8'hFF; err_ff <= '0; open_ff <= 1'b0;
         end else if (in_valid) begin
            phase_ff <= phase_in; off_ff <= off_in; opt_ff <= opt_in;
            olen_ff <= olen_in; orem_ff <= orem_in; acc_ff <= acc_in;
            hlen_ff <= hlen_in; mtype_ff <= mtype_in; err_ff <= err_in;
            open_ff <= 1'b1;
         end else if (csr_we && !open_ff) begin
            phase_ff <= start_of(csr_wdata);
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dpp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dpp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  dpp_pkg::entry_type      wr_data,
   output logic                    full,
   output logic                    empty,
   input  wire logic               rd_en,
   output dpp_pkg::entry_type      rd_data
);

   dpp_pkg::entry_type   mem_ff [dpp_pkg::QDEPTH];
   logic [dpp_pkg::QAW:0] wp_ff, rp_ff;

   assign empty   = (wp_ff == rp_ff);
   assign full    = (wp_ff[dpp_pkg::QAW] != rp_ff[dpp_pkg::QAW]) &&
                    (wp_ff[dpp_pkg::QAW-1:0] == rp_ff[dpp_pkg::QAW-1:0]);
   assign rd_data = mem_ff[rp_ff[dpp_pkg::QAW-1:0]];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff[dpp_pkg::QAW-1:0]] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dpp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dpp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  dpp_pkg::entry_type      q_data,
   output logic                    q_pop,
   output logic                    out_valid,
   output dpp_pkg::rec_type        out_rec,
   input  wire logic               out_ready
);

   // The second record of an entry is sent after the first one.
   logic            sel_ff, sel_in;
   logic            has0, has1, cur_v, done;

   assign has0  = !q_empty && q_data.v0;
   assign has1  = !q_empty && q_data.v1;
   assign cur_v = sel_ff ? has1 : has0;
   assign out_valid = cur_v;
   assign out_rec   = sel_ff ? q_data.r1 : q_data.r0;

   always_comb begin
      sel_in = sel_ff;
      done = 1'b0;
      if (!q_empty) begin
         if (!sel_ff) begin
            if (!has0 || out_ready) begin
               if (has1) sel_in = 1'b1;
               else done = 1'b1;
            end
         end else if (out_ready) begin
            sel_in = 1'b0; done = 1'b1;
         end
      end
   end
   assign q_pop = done;

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b0;
      else sel_ff <= sel_in;
   end

endmodule
`default_nettype wire

// ----- rtl/dpp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [4:0]  rsp_record_kind,
   input wire logic [31:0] rsp_record_value,
   input wire logic [3:0]  rsp_packet_status,
   input wire logic        rsp_end_of_packet
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record_value))
      else $error("rsp word changed while stalled");

   a_eop_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_packet |-> rsp_record_kind == 5'd18)
      else $error("end of packet on non-status word");

   a_status_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_packet |-> rsp_record_value == {28'd0, rsp_packet_status})
      else $error("status value mismatch");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_packet |-> rsp_packet_status <= 4'd9)
      else $error("status out of range");

endmodule

bind dhcp_packet_parser dpp_checker u_dpp_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_record_kind,
   .rsp_record_value, .rsp_packet_status, .rsp_end_of_packet
);
`default_nettype wire
